### rtl/psdds_pkg.sv
// shared types, widths and constants of the polynomial sine oscillator
package psdds_pkg;

    localparam int PHASE_W   = 16;
    localparam int SAMPLE_W  = 16;
    localparam int X_W       = 15;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = COEF_W + X_W + 1;
    localparam int ACC_W     = 32;
    localparam int OUT_SHIFT = 12;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic signed [COEF_W-1:0] COEF_A1 = 16'sd12868;
    localparam logic signed [COEF_W-1:0] COEF_A3 = -16'sd21167;
    localparam logic signed [COEF_W-1:0] COEF_A5 = 16'sd10445;
    localparam logic signed [COEF_W-1:0] COEF_A7 = -16'sd2455;

    localparam logic [X_W-1:0] FOLD_POINT = 15'd16384;
    localparam logic [X_W-1:0] FOLD_TOP   = 15'd32767;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 32'sd2048;

    localparam logic [PHASE_W-1:0] STEP_RESET = 16'd136;

    // folded phase word handed from front to back
    typedef struct packed {
        logic [X_W-1:0] x;
        logic           neg;
        logic           last;
    } item_t;

    // queue fill status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

### rtl/psdds_front.sv
// front end: phase accumulator, step register and phase folding
module psdds_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic                                  s_last,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psdds_pkg::PHASE_W-1:0]         cfg_data,
    input  psdds_pkg::q_status_t                  q_status,
    output logic                                  push,
    output psdds_pkg::item_t                      push_item
);
    import psdds_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] step_reg, step_next;
    logic [PHASE_W-1:0] phase_neg;
    logic [X_W-1:0]     mag;

    assign s_tready  = !q_status.full;
    assign cfg_ready = 1'b1;
    assign push      = s_tvalid && s_tready;

    // magnitude, most negative phase taken as full scale, then fold about the quarter
    always_comb begin
        phase_neg = PHASE_W'(-phase_reg);
        if (phase_reg == {1'b1, {(PHASE_W-1){1'b0}}}) begin
            mag = FOLD_TOP;
        end else if (phase_reg[PHASE_W-1]) begin
            mag = phase_neg[X_W-1:0];
        end else begin
            mag = phase_reg[X_W-1:0];
        end
        push_item.x    = (mag > FOLD_POINT) ? X_W'(FOLD_TOP - mag) : mag;
        push_item.neg  = phase_reg[PHASE_W-1];
        push_item.last = s_last;
    end

    always_comb begin
        phase_next = push ? PHASE_W'(phase_reg + step_reg) : phase_reg;
        step_next  = (cfg_valid && cfg_ready) ? cfg_data : step_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            step_reg  <= STEP_RESET;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    a_phase_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> phase_reg == PHASE_W'($past(phase_reg) + $past(step_reg)))
        else $error("phase did not advance by the step");

endmodule

### rtl/psdds_queue.sv
// short fifo between the front end and the polynomial engine
module psdds_queue #(
    parameter int DEPTH = psdds_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  psdds_pkg::item_t      push_item,
    input  logic                  pop,
    output psdds_pkg::item_t      pop_item,
    output psdds_pkg::q_status_t  q_status
);
    import psdds_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push  = push && !q_status.full;
    assign do_pop   = pop && !q_status.empty;
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !push)
        else $error("write into a full queue");

endmodule

### rtl/psdds_back.sv
// polynomial engine: shared multiplier sequencer and output register
module psdds_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  psdds_pkg::q_status_t              q_status,
    output logic                              pop,
    input  psdds_pkg::item_t                  pop_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [psdds_pkg::SAMPLE_W-1:0]    m_sample,
    output logic                              m_last
);
    import psdds_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_X2, ST_X3, ST_X5, ST_X7, ST_A1, ST_A3, ST_A5, ST_A7, ST_FIN
    } state_t;

    localparam int SH_W = ACC_W - OUT_SHIFT;

    state_t                    state_reg, state_next;
    logic [X_W-1:0]            x_reg, x_next;
    logic [X_W-1:0]            x2_reg, x2_next;
    logic [X_W-1:0]            x3_reg, x3_next;
    logic [X_W-1:0]            x5_reg, x5_next;
    logic [X_W-1:0]            x7_reg, x7_next;
    logic                      neg_reg, neg_next;
    logic                      last_reg, last_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic                      m_last_reg, m_last_next;

    logic signed [COEF_W-1:0]  mul_a;
    logic [X_W-1:0]            mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [X_W-1:0]            pow_res;
    logic signed [ACC_W-1:0]   y_signed;
    logic signed [ACC_W-1:0]   y_round;
    logic signed [SH_W-1:0]    y_shift;
    logic [SAMPLE_W-1:0]       y_sat;
    logic                      out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign m_valid  = m_valid_reg;
    assign m_sample = sample_reg;
    assign m_last   = m_last_reg;

    // operand select for the one multiplier
    always_comb begin
        case (state_reg)
            ST_X2:   begin mul_a = COEF_W'(signed'({1'b0, x_reg}));  mul_b = x_reg;  end
            ST_X3:   begin mul_a = COEF_W'(signed'({1'b0, x2_reg})); mul_b = x_reg;  end
            ST_X5:   begin mul_a = COEF_W'(signed'({1'b0, x2_reg})); mul_b = x3_reg; end
            ST_X7:   begin mul_a = COEF_W'(signed'({1'b0, x2_reg})); mul_b = x5_reg; end
            ST_A1:   begin mul_a = COEF_A1; mul_b = x_reg;  end
            ST_A3:   begin mul_a = COEF_A3; mul_b = x3_reg; end
            ST_A5:   begin mul_a = COEF_A5; mul_b = x5_reg; end
            ST_A7:   begin mul_a = COEF_A7; mul_b = x7_reg; end
            default: begin mul_a = '0;      mul_b = '0;     end
        endcase
        prod    = PROD_W'(mul_a) * signed'({1'b0, mul_b});
        // q15 product of non-negative operands, never reaches saturation
        pow_res = prod[2*X_W-1:X_W];
    end

    // sign, rounding, shift and clamp
    always_comb begin
        y_signed = neg_reg ? ACC_W'(-acc_reg) : acc_reg;
        y_round  = ACC_W'(y_signed + ROUND_BIAS);
        y_shift  = SH_W'(y_round >>> OUT_SHIFT);
        if (y_shift > SH_W'(32767)) begin
            y_sat = 16'h7FFF;
        end else if (y_shift < -SH_W'(32768)) begin
            y_sat = 16'h8000;
        end else begin
            y_sat = y_shift[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        x3_next      = x3_reg;
        x5_next      = x5_reg;
        x7_next      = x7_reg;
        neg_next     = neg_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        sample_next  = sample_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    x_next     = pop_item.x;
                    neg_next   = pop_item.neg;
                    last_next  = pop_item.last;
                    state_next = ST_X2;
                end
            end
            ST_X2: begin x2_next = pow_res; state_next = ST_X3; end
            ST_X3: begin x3_next = pow_res; state_next = ST_X5; end
            ST_X5: begin x5_next = pow_res; state_next = ST_X7; end
            ST_X7: begin x7_next = pow_res; state_next = ST_A1; end
            ST_A1: begin acc_next = ACC_W'(prod); state_next = ST_A3; end
            ST_A3: begin acc_next = ACC_W'(acc_reg + ACC_W'(prod)); state_next = ST_A5; end
            ST_A5: begin acc_next = ACC_W'(acc_reg + ACC_W'(prod)); state_next = ST_A7; end
            ST_A7: begin acc_next = ACC_W'(acc_reg + ACC_W'(prod)); state_next = ST_FIN; end
            ST_FIN: begin
                if (out_free) begin
                    sample_next  = y_sat;
                    m_last_next  = last_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        x3_reg     <= x3_next;
        x5_reg     <= x5_next;
        x7_reg     <= x7_next;
        neg_reg    <= neg_next;
        last_reg   <= last_next;
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
        m_last_reg <= m_last_next;
    end

    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == ST_X2)
        else $error("queue read did not start the sequence");

    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && out_free |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("finished sample not loaded into output register");

endmodule

### rtl/polynomial_sine_dds.sv
// top level of the polynomial sine oscillator
//
//  channel  | dir | signals                          | word
//  ---------+-----+----------------------------------+-------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata        | one sample request
//  m_       | out | m_tvalid m_tready m_tdata m_tlast| one q15 sine sample
//  cfg_     | in  | cfg_valid cfg_ready cfg_data     | phase step (always ready)
//
// each sample passes through the polynomial engine in turn: one queue read, four
// power products and four coefficient products through the one shared
// multiplier, then the round and clamp step into the output register
// requests are taken while the queue (two entries by default) has room, so the front
// end runs ahead of the engine; the engine stalls only when the output register
// is still full at the clamp step
// reset (aresetn low, synchronous) clears the phase, sets the step to 136
// and empties queue and output register
module polynomial_sine_dds #(
    parameter int QUEUE_DEPTH = psdds_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request words
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [psdds_pkg::S_TDATA_W-1:0]       s_tdata,   // [0] last_in_block, rest zero
    // sample words
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [psdds_pkg::M_TDATA_W-1:0]       m_tdata,   // [15:0] sample
    output logic                                  m_tlast,
    // phase step register
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [psdds_pkg::PHASE_W-1:0]         cfg_data
);
    import psdds_pkg::*;

    item_t     push_item;
    item_t     pop_item;
    q_status_t q_status;
    logic      push;
    logic      pop;

    // phase accumulator and folding
    psdds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_last    (s_tdata[0]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue of folded phase words
    psdds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    // polynomial evaluation and output register
    psdds_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop      (pop),
        .pop_item (pop_item),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_sample (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

### sim/tb_polynomial_sine_dds.sv
// self-checking testbench of the polynomial sine oscillator
module tb_polynomial_sine_dds;
    import psdds_pkg::*;

    // cycles to let the polynomial engine settle once every sample is back
    localparam int ENGINE_SETTLE = 40;

    // one expected sample word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sine_word_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // [0] last_in_block, rest zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // [15:0] sample
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [PHASE_W-1:0]   cfg_data;

    // predictor state, advanced on every accepted request word
    logic signed [PHASE_W-1:0] phase_acc;
    logic signed [PHASE_W-1:0] phase_step;
    sine_word_t                expected_words[$];

    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold;
    int mismatches;

    polynomial_sine_dds u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // q15 fractional product, saturating at the top, floor on the shift
    function automatic longint q15_product(input longint a, input longint b);
        longint p;
        p = a * b * 2;
        if (p >= 64'sd2147483648)
            return 32767;
        return p >>> 16;
    endfunction

    // expected sample for one phase value
    function automatic logic signed [SAMPLE_W-1:0] sine_of_phase(
        input logic signed [PHASE_W-1:0] ph
    );
        longint mag;
        longint x2, x3, x5, x7;
        longint y, shifted;
        // most negative phase counts as the largest magnitude
        if (ph == -16'sd32768)
            mag = longint'(FOLD_TOP);
        else if (ph < 0)
            mag = -longint'(ph);
        else
            mag = longint'(ph);
        // fold the upper part of the quarter back down
        if (mag > longint'(FOLD_POINT))
            mag = longint'(FOLD_TOP) - mag;
        x2 = q15_product(mag, mag);
        x3 = q15_product(x2, mag);
        x5 = q15_product(x2, x3);
        x7 = q15_product(x2, x5);
        y = longint'(COEF_A1) * mag + longint'(COEF_A3) * x3
          + longint'(COEF_A5) * x5 + longint'(COEF_A7) * x7;
        if (ph < 0)
            y = -y;
        y = y + longint'(ROUND_BIAS);
        shifted = y >>> OUT_SHIFT;
        if (shifted > 32767)
            shifted = 32767;
        if (shifted < -32768)
            shifted = -32768;
        return shifted[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // sample receiver: random stalls plus a counted hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready = 1'b0;
                sink_hold--;
            end else begin
                m_tready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // compare each accepted sample word with the oldest expectation
    always @(posedge aclk) begin
        sine_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("sample with nothing expected", $signed(m_tdata), 0);
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want.sample)
                    report_mismatch("sample", $signed(m_tdata), want.sample);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // offer one request word; valid stays high after acceptance
    task automatic send_request(input bit last_flag);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid   = 1'b1;
        s_tdata    = '0;
        s_tdata[0] = last_flag;
        do @(posedge aclk); while (!s_tready);
        expected_words.push_back('{sample: sine_of_phase(phase_acc), last: last_flag});
        phase_acc = phase_acc + phase_step;
    endtask

    // buffers of random length closed by last, with the odd stray last
    task automatic send_buffers(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 16);
            for (int k = 0; k < len && sent < count; k++) begin
                send_request((k == len - 1) || ($urandom_range(19) == 0));
                sent++;
            end
        end
    endtask

    task automatic drain_samples();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (ENGINE_SETTLE) @(posedge aclk);
    endtask

    // step writes happen only with the block idle
    task automatic write_phase_step(input logic [PHASE_W-1:0] value);
        drain_samples();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        phase_step = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // default step straight after reset
    task automatic test_reset_defaults();
        for (int k = 0; k < 4; k++)
            send_request(k[0]);
    endtask

    // quarter-turn steps from the phase left by the previous test, a sample in each quarter
    task automatic test_quarter_turns();
        write_phase_step(16'd16384);
        for (int k = 0; k < 5; k++)
            send_request(k == 4);
    endtask

    // extreme steps, wrap in both directions and tiny steps around zero
    task automatic test_step_extremes();
        write_phase_step(16'h7fff);
        for (int k = 0; k < 4; k++)
            send_request(1'b0);
        write_phase_step(16'h8000);
        for (int k = 0; k < 3; k++)
            send_request(1'b1);
        write_phase_step(16'hffff);
        for (int k = 0; k < 3; k++)
            send_request(k == 2);
        write_phase_step(16'd1);
        for (int k = 0; k < 2; k++)
            send_request(k == 1);
    endtask

    // several step settings with random buffer content
    task automatic test_random_runs();
        logic [PHASE_W-1:0] step;
        for (int run = 0; run < 9; run++) begin
            case (run)
                0: step = 16'h7fff;
                1: step = 16'h8000;
                2: step = 16'd0;
                3: step = 16'd16385;
                default: step = PHASE_W'($urandom);
            endcase
            write_phase_step(step);
            // one run with no idling on either side
            src_idle_pct  = (run == 4) ? 0 : 12;
            sink_idle_pct = (run == 4) ? 0 : 12;
            send_buffers(90);
        end
        src_idle_pct  = 12;
        sink_idle_pct = 12;
    endtask

    // receiver holds off long enough for the request side to stall
    task automatic test_output_backpressure();
        write_phase_step(PHASE_W'($urandom));
        src_idle_pct = 0;
        @(posedge aclk);
        sink_hold = 400;
        send_buffers(30);
        src_idle_pct = 12;
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        phase_acc     = '0;
        phase_step    = STEP_RESET;
        src_idle_pct  = 12;
        sink_idle_pct = 12;
        sink_hold     = 0;
        mismatches    = 0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_quarter_turns();
        test_step_extremes();
        test_random_runs();
        test_output_backpressure();
        drain_samples();

        if (mismatches == 0)
            $display("PASS polynomial_sine_dds");
        else
            $display("FAIL polynomial_sine_dds");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("FAIL polynomial_sine_dds");
        $finish;
    end

endmodule

### files.f
rtl/psdds_pkg.sv
rtl/psdds_front.sv
rtl/psdds_queue.sv
rtl/psdds_back.sv
rtl/polynomial_sine_dds.sv
sim/tb_polynomial_sine_dds.sv
